### rtl/cpf_pkg.sv
// Shared types, constants and saturating helpers for the centrifugal particle force block.
package cpf_pkg;

	// Signed 64-bit fixed-point word
	typedef logic signed [63:0] word_t;

	localparam word_t WORD_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam word_t WORD_MIN = 64'sh8000_0000_0000_0000;

	// pi with 62 fraction bits
	localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C235;

	// Configuration register indexes
	localparam int CFG_INDEX_BITS = 2;
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_ROTATION_SPEED   = 2'd0,
		REG_LIQUID_DENSITY   = 2'd1,
		REG_LIQUID_VISCOSITY = 2'd2
	} cfg_reg_t;

	// Saturating add
	function automatic word_t sat_add(input word_t a, input word_t b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? WORD_MIN : WORD_MAX;
		end
		return word_t'(s[63:0]);
	endfunction

	// Saturating subtract
	function automatic word_t sat_sub(input word_t a, input word_t b);
		logic [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? WORD_MIN : WORD_MAX;
		end
		return word_t'(s[63:0]);
	endfunction

endpackage

### rtl/centrifugal_particle_force.sv
// Top level: centrifugal buoyancy plus Stokes drag force per particle, fully pipelined.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one particle per transaction: index,
//   x and z position, velocity, radius and mass. Output channel (out_valid/out_ready)
//   returns one transaction per particle with the index and the force increment.
//   The configuration port (cfg_wr_en, cfg_index, cfg_wr_data) writes rotation speed,
//   liquid density and liquid viscosity; write only while no particle is in flight.
//   Indexes beyond the register list are ignored.
// Throughput: one particle per cycle while the output buffer has room. The pipeline depth is
//   set by seven dependent 5-stage multipliers (density, buoyancy chain) plus the
//   entry, subtract and final add stages.
// Reset: arst_n clears the pipeline valid bits and the output buffer and loads the
//   registers with 1.0 rad/s, 1000 kg/m^3 and about 0.0018 Pa*s.
// Stall: results queue in a two-entry output buffer; in_ready drops and the whole
//   pipeline freezes only once both entries are occupied.
module centrifugal_particle_force #(
	parameter int FRACTION_BITS = 40,
	parameter int INDEX_BITS    = 20
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_wr_en,
	input  logic [cpf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [63:0]                        cfg_wr_data,
	// particle input
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [INDEX_BITS-1:0]              particle_index,
	input  logic signed [63:0]                 pos_x,
	input  logic signed [63:0]                 pos_z,
	input  logic signed [63:0]                 vel_x,
	input  logic signed [63:0]                 vel_y,
	input  logic signed [63:0]                 vel_z,
	input  logic [62:0]                        radius,
	input  logic [62:0]                        mass,
	// force output
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [INDEX_BITS-1:0]              out_index,
	output logic signed [63:0]                 force_x,
	output logic signed [63:0]                 force_y,
	output logic signed [63:0]                 force_z
);

	localparam int STAGES = 38;
	localparam int OUT_W  = INDEX_BITS + 192;

	localparam logic [63:0] PI_EXT = cpf_pkg::PI_Q62 >> (59 - FRACTION_BITS);
	localparam logic [63:0] K6     = (64'd6 * PI_EXT + 64'd4) >> 3;
	localparam logic [63:0] K43    = ((64'd4 * PI_EXT) / 64'd3 + 64'd4) >> 3;

	cpf_pkg::word_t rot_q;
	logic [62:0]    dens_q, visc_q;
	cpf_pkg::word_t dens_w, visc_w;

	logic               en;
	logic [STAGES-1:0]  vld_q;

	logic [INDEX_BITS-1:0] e_idx_s1, idx_s38;
	cpf_pkg::word_t e_x_s1, e_z_s1, e_vx_s1, e_vz_s1, e_nx_s1, e_ny_s1, e_r_s1, e_m_s1;
	cpf_pkg::word_t r_s6, vx_s6, vz_s6, rr_s6, kv_s6, ux_s6, uz_s6;
	cpf_pkg::word_t dx_s7, dz_s7;
	cpf_pkg::word_t r3_s11, c_s11, ny_s11, dx_s11, dz_s11;
	cpf_pkg::word_t kr3_s16, fxd_s16, fyd_s16, fzd_s16;
	cpf_pkg::word_t m_s21, disp_s21, md_s22, mw_s27, b_s32, x_s32, z_s32;
	cpf_pkg::word_t xb_s37, zb_s37, fxd_s37, fzd_s37;
	cpf_pkg::word_t fx_s38, fy_s38, fz_s38;
	logic [OUT_W-1:0] push_data, out_data;

	assign dens_w = {1'b0, dens_q};
	assign visc_w = {1'b0, visc_q};

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q  <= cpf_pkg::word_t'(64'd1 << FRACTION_BITS);
			dens_q <= 63'(64'd1000 << FRACTION_BITS);
			visc_q <= 63'd1979120930;
		end else if (cfg_wr_en) begin
			case (cpf_pkg::cfg_reg_t'(cfg_index))
				cpf_pkg::REG_ROTATION_SPEED:   rot_q  <= cpf_pkg::word_t'(cfg_wr_data);
				cpf_pkg::REG_LIQUID_DENSITY:   dens_q <= cfg_wr_data[62:0];
				cpf_pkg::REG_LIQUID_VISCOSITY: visc_q <= cfg_wr_data[62:0];
				default: ;
			endcase
		end
	end

	// Pipeline valid bits, advancing with the global enable
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[STAGES-2:0], in_valid};
		end
	end

	// Entry stage: capture transaction, negate x and vy
	always_ff @(posedge clk) begin
		if (en) begin
			e_idx_s1 <= particle_index;
			e_x_s1   <= pos_x;
			e_z_s1   <= pos_z;
			e_vx_s1  <= vel_x;
			e_vz_s1  <= vel_z;
			e_nx_s1  <= cpf_pkg::sat_sub('0, pos_x);
			e_ny_s1  <= cpf_pkg::sat_sub('0, vel_y);
			e_r_s1   <= {1'b0, radius};
			e_m_s1   <= {1'b0, mass};
		end
	end

	// Level 1 products: r^2, 6*pi*viscosity, fluid velocity
	cpf_fmul #(.FRACTION_BITS(FRACTION_BITS)) u_rr (
		.clk(clk), .en(en), .a(e_r_s1), .b(e_r_s1), .p(rr_s6));
	cpf_fmul #(.FRACTION_BITS(FRACTION_BITS)) u_kv (
		.clk(clk), .en(en), .a(cpf_pkg::word_t'(K6)), .b(visc_w), .p(kv_s6));
	cpf_fmul #(.FRACTION_BITS(FRACTION_BITS)) u_ux (
		.clk(clk), .en(en), .a(e_z_s1), .b(rot_q), .p(ux_s6));
	cpf_fmul #(.FRACTION_BITS(FRACTION_BITS)) u_uz (
		.clk(clk), .en(en), .a(e_nx_s1), .b(rot_q), .p(uz_s6));

	cpf_delay #(.WIDTH(64), .DEPTH(5)) u_d_r (
		.clk(clk), .en(en), .d(e_r_s1), .q(r_s6));
	cpf_delay #(.WIDTH(128), .DEPTH(5)) u_d_v (
		.clk(clk), .en(en), .d({e_vx_s1, e_vz_s1}), .q({vx_s6, vz_s6}));

	// Relative velocity
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s7 <= cpf_pkg::sat_sub(ux_s6, vx_s6);
			dz_s7 <= cpf_pkg::sat_sub(uz_s6, vz_s6);
		end
	end

	// Level 2 products: r^3 and drag coefficient
	cpf_fmul #(.FRACTION_BITS(FRACTION_BITS)) u_r3 (
		.clk(clk), .en(en), .a(rr_s6), .b(r_s6), .p(r3_s11));
	cpf_fmul #(.FRACTION_BITS(FRACTION_BITS)) u_c (
		.clk(clk), .en(en), .a(kv_s6), .b(r_s6), .p(c_s11));

	cpf_delay #(.WIDTH(64), .DEPTH(10)) u_d_ny (
		.clk(clk), .en(en), .d(e_ny_s1), .q(ny_s11));
	cpf_delay #(.WIDTH(128), .DEPTH(4)) u_d_dxz (
		.clk(clk), .en(en), .d({dx_s7, dz_s7}), .q({dx_s11, dz_s11}));

	// Level 3 products: volume term and drag forces
	cpf_fmul #(.FRACTION_BITS(FRACTION_BITS)) u_kr3 (
		.clk(clk), .en(en), .a(cpf_pkg::word_t'(K43)), .b(r3_s11), .p(kr3_s16));
	cpf_fmul #(.FRACTION_BITS(FRACTION_BITS)) u_fxd (
		.clk(clk), .en(en), .a(dx_s11), .b(c_s11), .p(fxd_s16));
	cpf_fmul #(.FRACTION_BITS(FRACTION_BITS)) u_fyd (
		.clk(clk), .en(en), .a(ny_s11), .b(c_s11), .p(fyd_s16));
	cpf_fmul #(.FRACTION_BITS(FRACTION_BITS)) u_fzd (
		.clk(clk), .en(en), .a(dz_s11), .b(c_s11), .p(fzd_s16));

	// Level 4: displaced liquid mass
	cpf_fmul #(.FRACTION_BITS(FRACTION_BITS)) u_disp (
		.clk(clk), .en(en), .a(kr3_s16), .b(dens_w), .p(disp_s21));

	cpf_delay #(.WIDTH(64), .DEPTH(20)) u_d_m (
		.clk(clk), .en(en), .d(e_m_s1), .q(m_s21));

	// Effective mass
	always_ff @(posedge clk) begin
		if (en) begin
			md_s22 <= cpf_pkg::sat_sub(m_s21, disp_s21);
		end
	end

	// Levels 5 and 6: buoyant factor times w^2
	cpf_fmul #(.FRACTION_BITS(FRACTION_BITS)) u_mw (
		.clk(clk), .en(en), .a(md_s22), .b(rot_q), .p(mw_s27));
	cpf_fmul #(.FRACTION_BITS(FRACTION_BITS)) u_b (
		.clk(clk), .en(en), .a(mw_s27), .b(rot_q), .p(b_s32));

	cpf_delay #(.WIDTH(128), .DEPTH(31)) u_d_xz (
		.clk(clk), .en(en), .d({e_x_s1, e_z_s1}), .q({x_s32, z_s32}));

	// Level 7: centrifugal force components
	cpf_fmul #(.FRACTION_BITS(FRACTION_BITS)) u_xb (
		.clk(clk), .en(en), .a(x_s32), .b(b_s32), .p(xb_s37));
	cpf_fmul #(.FRACTION_BITS(FRACTION_BITS)) u_zb (
		.clk(clk), .en(en), .a(z_s32), .b(b_s32), .p(zb_s37));

	cpf_delay #(.WIDTH(128), .DEPTH(21)) u_d_fxz (
		.clk(clk), .en(en), .d({fxd_s16, fzd_s16}), .q({fxd_s37, fzd_s37}));
	cpf_delay #(.WIDTH(64), .DEPTH(22)) u_d_fy (
		.clk(clk), .en(en), .d(fyd_s16), .q(fy_s38));
	cpf_delay #(.WIDTH(INDEX_BITS), .DEPTH(STAGES - 1)) u_d_idx (
		.clk(clk), .en(en), .d(e_idx_s1), .q(idx_s38));

	// Drag plus centrifugal
	always_ff @(posedge clk) begin
		if (en) begin
			fx_s38 <= cpf_pkg::sat_add(fxd_s37, xb_s37);
			fz_s38 <= cpf_pkg::sat_add(fzd_s37, zb_s37);
		end
	end

	// Output buffer
	assign push_data = {idx_s38, fx_s38, fy_s38, fz_s38};

	cpf_outbuf #(.WIDTH(OUT_W)) u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (en && vld_q[STAGES-1]),
		.push_data (push_data),
		.room      (en),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign out_index = out_data[OUT_W-1:192];
	assign force_x   = out_data[191:128];
	assign force_y   = out_data[127:64];
	assign force_z   = out_data[63:0];

	// A finished result always reaches the output
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_q[STAGES-1]) |=> out_valid)
		else $error("pushed result not visible on output");

	// The input only stalls while results are waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output buffer");

	// A frozen pipeline keeps its valid bits
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved while stalled");

endmodule

### rtl/cpf_fmul.sv
// Five-stage fixed-point multiplier: floor shift by the fraction width, saturated to 64 bits.
module cpf_fmul #(
	parameter int FRACTION_BITS = 40
) (
	input  logic           clk,
	input  logic           en,
	input  cpf_pkg::word_t a,
	input  cpf_pkg::word_t b,
	output cpf_pkg::word_t p
);

	localparam int F = FRACTION_BITS;

	logic [63:0] ua, ub, mag_a, mag_b;
	logic [63:0] ma_s1, mb_s1;
	logic        neg_s1, neg_s2, neg_s3, neg_s4;
	logic [63:0] p00_s2, p01_s2, p10_s2, p11_s2;
	logic [127:0] prod_s3;
	logic [65:0] q_s4;
	logic        hi_s4;
	logic        ovf;
	cpf_pkg::word_t p_s5;

	// Sign and magnitude of the operands
	assign ua    = a;
	assign ub    = b;
	assign mag_a = a[63] ? (~ua + 64'd1) : ua;
	assign mag_b = b[63] ? (~ub + 64'd1) : ub;

	// Overflow of the shifted magnitude
	always_comb begin
		if (neg_s4) begin
			ovf = hi_s4 || (|q_s4[65:64]) || (q_s4[63] && (|q_s4[62:0]));
		end else begin
			ovf = hi_s4 || (|q_s4[65:63]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: magnitudes
			ma_s1  <= mag_a;
			mb_s1  <= mag_b;
			neg_s1 <= a[63] ^ b[63];
			// s2: 32x32 partial products
			p00_s2 <= {32'd0, ma_s1[31:0]} * {32'd0, mb_s1[31:0]};
			p01_s2 <= {32'd0, ma_s1[31:0]} * {32'd0, mb_s1[63:32]};
			p10_s2 <= {32'd0, ma_s1[63:32]} * {32'd0, mb_s1[31:0]};
			p11_s2 <= {32'd0, ma_s1[63:32]} * {32'd0, mb_s1[63:32]};
			neg_s2 <= neg_s1;
			// s3: full 128-bit magnitude product
			prod_s3 <= {p11_s2, p00_s2} + {32'd0, p01_s2, 32'd0} + {32'd0, p10_s2, 32'd0};
			neg_s3  <= neg_s2;
			// s4: shift, bump toward minus infinity for negative results
			q_s4   <= {1'b0, prod_s3[F+64:F]} + 66'(neg_s3 && (prod_s3[F-1:0] != '0));
			hi_s4  <= |prod_s3[127:F+65];
			neg_s4 <= neg_s3;
			// s5: saturate and apply sign
			if (neg_s4) begin
				p_s5 <= ovf ? cpf_pkg::WORD_MIN : cpf_pkg::word_t'(~q_s4[63:0] + 64'd1);
			end else begin
				p_s5 <= ovf ? cpf_pkg::WORD_MAX : cpf_pkg::word_t'(q_s4[63:0]);
			end
		end
	end

	assign p = p_s5;

endmodule

### rtl/cpf_delay.sv
// Enabled shift line that keeps operands aligned with the multiplier pipeline.
module cpf_delay #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] line_q [DEPTH];

	// Shift one place per advancing cycle
	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign q = line_q[DEPTH-1];

endmodule

### rtl/cpf_outbuf.sv
// Two-entry output buffer that decouples the pipeline from the result receiver.
module cpf_outbuf #(
	parameter int WIDTH = 212
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             pop;

	assign room      = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = slot_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule
